// ===== rtl/core/fsd_pkg.sv =====
// Package for the frame seam declicker: register codes, field widths,
// fixed-point constants and the cosine series tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fsd_pkg;

  // Configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_LENGTH = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CHUNK_FRAMES = 1'd1;

  // Register and counter widths
  localparam int FRAME_LEN_W = 17;
  localparam int CHUNK_W     = 7;
  localparam int FRAME_POS_W = 16;
  localparam int CHUNK_POS_W = 6;
  localparam int FADE_SHIFT  = 4;   // fade length is frame_length / 16

  localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RESET = 17'd2048;
  localparam logic [CHUNK_W-1:0]     CHUNK_RESET     = 7'd1;
  localparam logic [FRAME_LEN_W-1:0] MAX_FRAME       = 17'd65536;
  localparam logic [CHUNK_W-1:0]     MAX_CHUNK       = 7'd64;
  localparam int                     MIN_FADE        = 8;

  // Fixed point: angle fraction and cosine in Q30
  localparam int                 FRAC_W  = 30;
  localparam int                 TURN_W  = 30;  // t = num * 2^30 / len, always below 2^30
  localparam logic [31:0]        PI_Q30  = 32'd3373259426;
  localparam logic signed [32:0] Q30_ONE = 33'sd1073741824;

  // Decay rounding to Q1.16
  localparam int           DECAY_W     = 17;
  localparam logic [16:0]  DECAY_ONE   = 17'd65536;
  localparam int           Q16_SHIFT   = 14;
  localparam int           Q16_HALF    = 13;
  localparam int           CORR_SHIFT  = 16;

  // Shared multiplier
  localparam int MUL_AW = 33;
  localparam int MUL_BW = 32;
  localparam int MUL_PW = 65;
  localparam int RECIP_SHIFT = 32;

  // Horner steps of the cosine series, with floor(2^32 / k) for each divisor
  localparam int HORNER_STEPS = 6;
  localparam logic [7:0] HORNER_K [HORNER_STEPS] = '{
    8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
  };
  localparam logic [31:0] HORNER_RECIP [HORNER_STEPS] = '{
    32'((64'd1 << 32) / 64'd132),
    32'((64'd1 << 32) / 64'd90),
    32'((64'd1 << 32) / 64'd56),
    32'((64'd1 << 32) / 64'd30),
    32'((64'd1 << 32) / 64'd12),
    32'((64'd1 << 32) / 64'd2)
  };

endpackage

`default_nettype wire

// ===== rtl/core/fsd_mul.sv =====
// Shared unsigned multiplier of the declicker with a registered product.
// Depends on fsd_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none

module fsd_mul (
  input  wire logic                      clk,
  input  wire logic [fsd_pkg::MUL_AW-1:0] a,
  input  wire logic [fsd_pkg::MUL_BW-1:0] b,
  output logic      [fsd_pkg::MUL_PW-1:0] prod
);

  localparam int PW = fsd_pkg::MUL_PW;

  // one multiply per cycle, registered product
  always_ff @(posedge clk) begin
    prod <= PW'(a) * PW'(b);
  end

endmodule

`default_nettype wire

// ===== rtl/core/fsd_div.sv =====
// Bit-serial restoring divider: quo = floor(num * 2^30 / den), num < den.
// Depends on fsd_pkg for the quotient width.
`timescale 1ns / 1ps
`default_nettype none

module fsd_div #(
  parameter int LEN_W = 9
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [LEN_W-1:0]           num,
  input  wire logic [LEN_W-1:0]           den,
  output logic                            done,
  output logic [fsd_pkg::TURN_W-1:0]      quo
);

  localparam int TW    = fsd_pkg::TURN_W;
  localparam int CNT_W = $clog2(TW + 1);

  logic [LEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [LEN_W:0]   rem_sh;
  logic [LEN_W:0]   trial;
  logic             fits;

  // one quotient bit per cycle
  always_comb begin
    rem_sh = {rem, 1'b0};
    trial  = rem_sh - {1'b0, den};
    fits   = (rem_sh >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= num;
        cnt  <= CNT_W'(TW);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? trial[LEN_W-1:0] : rem_sh[LEN_W-1:0];
        quo <= {quo[TW-2:0], fits};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fsd_core.sv =====
// Decay and correction sequencer: raised-cosine weight of one sample and
// the rounded, saturated seam correction, all on one shared multiplier.
// Depends on fsd_pkg, fsd_mul and fsd_div.
`timescale 1ns / 1ps
`default_nettype none

module fsd_core #(
  parameter int SAMPLE_BITS = 24,
  parameter int LEN_W       = 9
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [LEN_W-1:0]              pos,
  input  wire logic [LEN_W-1:0]              len,
  input  wire logic signed [SAMPLE_BITS:0]   gap,
  input  wire logic signed [SAMPLE_BITS-1:0] x,
  output logic                               done,
  output logic signed [SAMPLE_BITS-1:0]      y
);

  localparam int SB     = SAMPLE_BITS;
  localparam int FRAC_W = fsd_pkg::FRAC_W;
  localparam int AW     = fsd_pkg::MUL_AW;
  localparam int BW     = fsd_pkg::MUL_BW;
  localparam int PW     = fsd_pkg::MUL_PW;
  localparam int DW     = fsd_pkg::DECAY_W;
  localparam int PRW    = SB + DW;     // |gap| * decay
  localparam int SUM_W  = SB + 2;
  localparam int KI_W   = $clog2(fsd_pkg::HORNER_STEPS);
  localparam logic [KI_W-1:0] K_LAST = KI_W'(fsd_pkg::HORNER_STEPS - 1);

  typedef enum logic [3:0] {
    C_IDLE, C_DIV, C_TPI, C_AA, C_Z, C_HP, C_H1, C_H2, C_H3, C_D, C_G, C_C
  } cstate_t;

  cstate_t                   state;
  logic                      folded;
  logic [KI_W-1:0]           kidx;
  logic [31:0]               z;
  logic [31:0]               xr;
  logic [31:0]               q0;
  logic signed [32:0]        p;
  logic [DW-1:0]             d;
  logic [SB:0]               g_mag;
  logic                      gneg;
  logic signed [SB-1:0]      x_hold;

  logic                      div_start;
  logic                      div_done;
  logic [LEN_W-1:0]          div_num;
  logic [fsd_pkg::TURN_W-1:0] quo;
  logic                      fold_now;

  logic [AW-1:0]             mul_a;
  logic [BW-1:0]             mul_b;
  logic [PW-1:0]             prod;
  logic [31:0]               mid;
  logic [31:0]               hi;

  logic [32:0]               p_abs;
  logic [32:0]               rem_k;
  logic                      q_up;
  logic [32:0]               q;
  logic signed [32:0]        p_new;
  logic signed [33:0]        v;
  logic [32:0]               dd;
  logic [32:0]               dd_rnd;
  logic [18:0]               dr;
  logic [DW-1:0]             d_next;
  logic [PRW-1:0]            corr_rnd;
  logic [SB:0]               corr;
  logic signed [SUM_W-1:0]   y_wide;
  logic                      y_fits;
  logic signed [SB-1:0]      y_next;

  // Angle fold and divider launch
  always_comb begin
    fold_now  = ({pos, 1'b0} > {1'b0, len});
    div_num   = fold_now ? (len - pos) : pos;
    div_start = (state == C_IDLE) && start;
  end

  fsd_div #(.LEN_W(LEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (len),
    .done  (div_done),
    .quo   (quo)
  );

  // Product slices: Q30 rescale and reciprocal rescale
  assign mid = prod[FRAC_W +: 32];
  assign hi  = prod[fsd_pkg::RECIP_SHIFT +: 32];

  // Horner step: floor(x / k) via reciprocal, one correction
  always_comb begin
    p_abs = p[32] ? $unsigned(-p) : $unsigned(p);
    rem_k = {1'b0, xr} - prod[32:0];
    q_up  = (rem_k >= {25'd0, fsd_pkg::HORNER_K[kidx]});
    q     = {1'b0, q0} + 33'(q_up);
    p_new = p[32] ? (fsd_pkg::Q30_ONE + $signed(q)) : (fsd_pkg::Q30_ONE - $signed(q));
  end

  // Decay (1 +/- cos)/2 rounded to Q1.16
  always_comb begin
    v      = folded ? (34'(fsd_pkg::Q30_ONE) - 34'(p)) : (34'(fsd_pkg::Q30_ONE) + 34'(p));
    dd     = v[33] ? '0 : $unsigned(v[33:1]);
    dd_rnd = dd + (33'd1 << fsd_pkg::Q16_HALF);
    dr     = dd_rnd[32:fsd_pkg::Q16_SHIFT];
    d_next = (dr > 19'(fsd_pkg::DECAY_ONE)) ? fsd_pkg::DECAY_ONE : dr[DW-1:0];
  end

  // Rounded correction and saturation
  always_comb begin
    corr_rnd = prod[PRW-1:0] + (PRW'(1) << (fsd_pkg::CORR_SHIFT - 1));
    corr     = corr_rnd[PRW-1:fsd_pkg::CORR_SHIFT];
    y_wide   = gneg ? ({{2{x_hold[SB-1]}}, x_hold} - {1'b0, corr})
                    : ({{2{x_hold[SB-1]}}, x_hold} + {1'b0, corr});
    y_fits   = (y_wide[SUM_W-1 -: 3] == 3'b000) || (y_wide[SUM_W-1 -: 3] == 3'b111);
    if (y_fits) begin
      y_next = y_wide[SB-1:0];
    end else if (y_wide[SUM_W-1]) begin
      y_next = {1'b1, {(SB-1){1'b0}}};
    end else begin
      y_next = {1'b0, {(SB-1){1'b1}}};
    end
  end

  // Multiplier operand select
  always_comb begin
    unique case (state)
      C_TPI: begin
        mul_a = AW'(quo);
        mul_b = fsd_pkg::PI_Q30;
      end
      C_AA: begin
        mul_a = AW'(mid);
        mul_b = mid;
      end
      C_HP: begin
        mul_a = AW'(z);
        mul_b = p_abs[BW-1:0];
      end
      C_H1: begin
        mul_a = AW'(mid);
        mul_b = fsd_pkg::HORNER_RECIP[kidx];
      end
      C_H2: begin
        mul_a = AW'(hi);
        mul_b = BW'(fsd_pkg::HORNER_K[kidx]);
      end
      C_G: begin
        mul_a = AW'(g_mag);
        mul_b = BW'(d);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  fsd_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (start) begin
            folded <= fold_now;
            gneg   <= gap[SB];
            g_mag  <= gap[SB] ? $unsigned(-gap) : $unsigned(gap);
            x_hold <= x;
            state  <= C_DIV;
          end
        end
        C_DIV: begin
          if (div_done) begin
            state <= C_TPI;
          end
        end
        C_TPI: state <= C_AA;
        C_AA:  state <= C_Z;
        C_Z: begin
          z     <= mid;
          p     <= fsd_pkg::Q30_ONE;
          kidx  <= '0;
          state <= C_HP;
        end
        C_HP: state <= C_H1;
        C_H1: begin
          xr    <= mid;
          state <= C_H2;
        end
        C_H2: begin
          q0    <= hi;
          state <= C_H3;
        end
        C_H3: begin
          p <= p_new;
          if (kidx == K_LAST) begin
            state <= C_D;
          end else begin
            kidx  <= kidx + KI_W'(1);
            state <= C_HP;
          end
        end
        C_D: begin
          d     <= d_next;
          state <= C_G;
        end
        C_G: state <= C_C;
        C_C: begin
          y     <= y_next;
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/frame_seam_declicker.sv =====
// Frame seam declicker top level: frame and chunk tracking, handshakes,
// output register. Depends on fsd_pkg and fsd_core.
//
// Usage:
//   Samples enter on in_valid/in_stall and leave on out_valid/out_stall, one
//   result beat per input beat, in order, with frame_start marking the first
//   sample of each frame. The config port (cfg_wr_en, cfg_addr, cfg_wdata)
//   writes frame_length (index 0) or chunk_frames (index 1); writing
//   frame_length also restarts the frame and chunk count.
//   Timing: one sample at a time. A sample outside the crossfade window
//   passes through the result register into the output register. A sample
//   inside the window first runs the bit-serial angle divider and its
//   handoff, then the sequencer on the shared 33x32 multiplier (angle,
//   square, six Horner rounds, decay rounding, correction), and then
//   passes through the result register into the output register.
//   in_stall is high from the accept until the result moves to the output
//   register; one finished beat may wait there while the next sample is
//   accepted. A stalled output holds its beat; the block then stops after
//   computing the following sample.
//   Reset (rst, synchronous) empties the output register, restores
//   frame_length 2048 and chunk_frames 1 and clears all seam state.
`timescale 1ns / 1ps
`default_nettype none

module frame_seam_declicker #(
  parameter int SAMPLE_BITS   = 24,
  parameter int MAX_CROSSFADE = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [fsd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [fsd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]     sample_in,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [SAMPLE_BITS-1:0]          sample_out,
  output logic                                   frame_start
);

  localparam int SB         = SAMPLE_BITS;
  localparam int LEN_W      = $clog2(MAX_CROSSFADE + 1);
  localparam int FL_W       = fsd_pkg::FRAME_LEN_W;
  localparam int CF_W       = fsd_pkg::CHUNK_W;
  localparam int FP_W       = fsd_pkg::FRAME_POS_W;
  localparam int CP_W       = fsd_pkg::CHUNK_POS_W;
  localparam int FADE_RAW_W = FL_W - fsd_pkg::FADE_SHIFT;

  typedef enum logic [1:0] {T_IDLE, T_CALC, T_PUSH} tstate_t;

  tstate_t               tstate;
  logic [FL_W-1:0]       frame_length;
  logic [CF_W-1:0]       chunk_frames;
  logic [FP_W-1:0]       frame_position;
  logic [CP_W-1:0]       chunk_position;
  logic signed [SB-1:0]  previous_last_sample;
  logic                  have_previous_tail;
  logic signed [SB:0]    seam_gap;
  logic                  declick_active;
  logic signed [SB-1:0]  res_sample;
  logic                  res_start;

  logic [FL_W-1:0]       fl_eff;
  logic [CF_W-1:0]       cf_eff;
  logic [FADE_RAW_W-1:0] fade_raw;
  logic [LEN_W-1:0]      fade;
  logic                  start_pos;
  logic                  act;
  logic signed [SB:0]    gap_new;
  logic                  in_window;
  logic                  frame_end;
  logic [CP_W-1:0]       chunk_next;
  logic                  accept;
  logic                  core_start;
  logic                  core_done;
  logic signed [SB-1:0]  core_y;

  // Clamped frame, chunk and fade lengths
  always_comb begin
    if (frame_length == '0) begin
      fl_eff = FL_W'(1);
    end else if (frame_length > fsd_pkg::MAX_FRAME) begin
      fl_eff = fsd_pkg::MAX_FRAME;
    end else begin
      fl_eff = frame_length;
    end
    if (chunk_frames == '0) begin
      cf_eff = CF_W'(1);
    end else if (chunk_frames > fsd_pkg::MAX_CHUNK) begin
      cf_eff = fsd_pkg::MAX_CHUNK;
    end else begin
      cf_eff = chunk_frames;
    end
    fade_raw = frame_length[FL_W-1:fsd_pkg::FADE_SHIFT];
    if (fade_raw < FADE_RAW_W'(fsd_pkg::MIN_FADE)) begin
      fade = LEN_W'(fsd_pkg::MIN_FADE);
    end else if (fade_raw > FADE_RAW_W'(MAX_CROSSFADE)) begin
      fade = LEN_W'(MAX_CROSSFADE);
    end else begin
      fade = fade_raw[LEN_W-1:0];
    end
  end

  // Seam decision for the sample at the input
  always_comb begin
    start_pos  = (frame_position == '0);
    act        = start_pos ? (have_previous_tail && (chunk_position == '0)) : declick_active;
    gap_new    = (start_pos && act)
                 ? ({previous_last_sample[SB-1], previous_last_sample}
                    - {sample_in[SB-1], sample_in})
                 : seam_gap;
    in_window  = act && (frame_position < FP_W'(fade));
    frame_end  = ((FL_W'(frame_position) + FL_W'(1)) >= fl_eff);
    chunk_next = ((CF_W'(chunk_position) + CF_W'(1)) >= cf_eff) ? '0
                 : (chunk_position + CP_W'(1));
  end

  assign in_stall   = (tstate != T_IDLE);
  assign accept     = in_valid && !in_stall;
  assign core_start = accept && in_window;

  fsd_core #(.SAMPLE_BITS(SB), .LEN_W(LEN_W)) u_core (
    .clk   (clk),
    .rst   (rst),
    .start (core_start),
    .pos   (frame_position[LEN_W-1:0]),
    .len   (fade),
    .gap   (gap_new),
    .x     (sample_in),
    .done  (core_done),
    .y     (core_y)
  );

  // Control, frame state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      tstate               <= T_IDLE;
      out_valid            <= 1'b0;
      frame_length         <= fsd_pkg::FRAME_LEN_RESET;
      chunk_frames         <= fsd_pkg::CHUNK_RESET;
      frame_position       <= '0;
      chunk_position       <= '0;
      previous_last_sample <= '0;
      have_previous_tail   <= 1'b0;
      seam_gap             <= '0;
      declick_active       <= 1'b0;
    end else begin
      // output beat taken and nothing ready to replace it
      if (out_valid && !out_stall && (tstate != T_PUSH)) begin
        out_valid <= 1'b0;
      end

      unique case (tstate)
        T_IDLE: begin
          if (accept) begin
            res_start <= start_pos;
            seam_gap  <= gap_new;
            if (frame_end) begin
              previous_last_sample <= sample_in;
              have_previous_tail   <= 1'b1;
              chunk_position       <= chunk_next;
              frame_position       <= '0;
              declick_active       <= 1'b0;
            end else begin
              frame_position <= frame_position + FP_W'(1);
              declick_active <= act;
            end
            if (in_window) begin
              tstate <= T_CALC;
            end else begin
              res_sample <= sample_in;
              tstate     <= T_PUSH;
            end
          end
        end
        T_CALC: begin
          if (core_done) begin
            res_sample <= core_y;
            tstate     <= T_PUSH;
          end
        end
        T_PUSH: begin
          if (!out_valid || !out_stall) begin
            sample_out  <= res_sample;
            frame_start <= res_start;
            out_valid   <= 1'b1;
            tstate      <= T_IDLE;
          end
        end
        default: tstate <= T_IDLE;
      endcase

      // register writes; the user must issue them only with no sample in flight, the block does not enforce it
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          fsd_pkg::REG_FRAME_LENGTH: begin
            frame_length         <= cfg_wdata[FL_W-1:0];
            frame_position       <= '0;
            chunk_position       <= '0;
            previous_last_sample <= '0;
            have_previous_tail   <= 1'b0;
            seam_gap             <= '0;
            declick_active       <= 1'b0;
          end
          fsd_pkg::REG_CHUNK_FRAMES: begin
            chunk_frames <= cfg_wdata[CF_W-1:0];
          end
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fsd_check.sv =====
// Port-level checker for the frame seam declicker, bound to the top level.
// Depends only on the top level's handshake and result ports.
`timescale 1ns / 1ps
`default_nettype none

module fsd_check #(
  parameter int SAMPLE_BITS = 24
) (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic signed [SAMPLE_BITS-1:0]  sample_out,
  input wire logic                           frame_start
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // beats accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      unique case ({in_acc, out_acc})
        2'b10:   pending <= pending + 2'd1;
        2'b01:   pending <= pending - 2'd1;
        default: pending <= pending;
      endcase
    end
  end

  // no result beat without an earlier sample
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> (pending != 2'd0))
    else $error("result beat without a pending sample");

  // at most one sample in work plus one in the output register
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two samples outstanding");

  // one sample at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> in_stall)
    else $error("input accepted back to back");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(sample_out) && $stable(frame_start)))
    else $error("stalled result beat changed");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind frame_seam_declicker fsd_check #(.SAMPLE_BITS(SAMPLE_BITS)) u_fsd_check (.*);

`default_nettype wire

// ===== test/tb_frame_seam_declicker.sv =====
// Testbench for frame_seam_declicker: directed seam, frame and chunk cases, then
// random streams under several register settings, all checked against an in-bench
// predictor. Depends on fsd_pkg and the frame_seam_declicker RTL.
`timescale 1ns / 1ps

module tb_frame_seam_declicker;

  localparam int unsigned RUN_LIMIT  = 1000000;
  localparam longint      Q30        = 64'sd1073741824;
  localparam longint      SAMPLE_MAX = 64'sd8388607;
  localparam longint      SAMPLE_MIN = -64'sd8388608;
  localparam int unsigned FADE_MAX   = 256;
  localparam int          CFG_W      = fsd_pkg::CFG_DATA_W;

  // One output beat as the block should produce it
  typedef struct packed {
    logic signed [23:0] audio;
    logic               head;
  } declick_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [fsd_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [fsd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [23:0] sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [23:0] sample_out;
  logic frame_start;

  // Idle rates in percent, set before the directed tests and per random-stream test
  int source_gap_pct = 0;
  int sink_stall_pct = 0;

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  declick_beat_t awaited_beats[$];
  declick_beat_t oldest_beat;

  // Predictor copy of registers and seam state
  logic [fsd_pkg::FRAME_LEN_W-1:0] pred_frame_len;
  logic [fsd_pkg::CHUNK_W-1:0]     pred_chunk_frames;
  int unsigned pred_frame_pos;
  int unsigned pred_chunk_pos;
  longint      pred_tail;
  bit          pred_tail_seen;
  longint      pred_gap;
  bit          pred_fading;

  frame_seam_declicker dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample_in   (sample_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample_out  (sample_out),
    .frame_start (frame_start)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver backpressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  function automatic void clear_seam_state();
    pred_frame_pos = 0;
    pred_chunk_pos = 0;
    pred_tail = 0;
    pred_tail_seen = 1'b0;
    pred_gap = 0;
    pred_fading = 1'b0;
  endfunction

  // Raised-cosine weight at position i of a fade of len samples, Q1.16 (one = 65536)
  function automatic longint decay_weight(input int unsigned i, input int unsigned len);
    bit folded;
    longint unsigned num, t, a;
    longint z, p, d;
    folded = (2 * i > len);
    num = folded ? len - i : i;
    t = (num << 30) / len;
    a = (t * fsd_pkg::PI_Q30) >> 30;
    z = longint'((a * a) >> 30);
    p = Q30;
    // cosine series, each division truncating toward zero
    for (int k = 0; k < fsd_pkg::HORNER_STEPS; k++)
      p = Q30 - (z * p) / (longint'(fsd_pkg::HORNER_K[k]) * Q30);
    d = folded ? (Q30 - p) / 2 : (Q30 + p) / 2;
    if (d < 0) d = 0;
    d = (d + 8192) / 16384;
    if (d > 65536) d = 65536;
    return d;
  endfunction

  // Advance the seam state by one accepted sample and return the beat it yields
  function automatic declick_beat_t predict_declick(input logic signed [23:0] x);
    int unsigned frame_len, chunk_len, fade_len;
    longint xs, y, w, gap_abs, corr;
    bit head;
    declick_beat_t beat;
    frame_len = pred_frame_len;
    if (frame_len == 0) frame_len = 1;
    if (frame_len > 65536) frame_len = 65536;
    chunk_len = pred_chunk_frames;
    if (chunk_len == 0) chunk_len = 1;
    if (chunk_len > 64) chunk_len = 64;
    fade_len = pred_frame_len / 16;
    if (fade_len < 8) fade_len = 8;
    if (fade_len > FADE_MAX) fade_len = FADE_MAX;

    xs = x;
    y = xs;
    head = (pred_frame_pos == 0);

    // latch the seam gap at the first sample of a chunk
    if (head) begin
      if (pred_tail_seen && pred_chunk_pos == 0) begin
        pred_gap = pred_tail - xs;
        pred_fading = 1'b1;
      end else begin
        pred_fading = 1'b0;
      end
    end

    if (pred_fading && pred_frame_pos < fade_len) begin
      w = decay_weight(pred_frame_pos, fade_len);
      gap_abs = (pred_gap < 0) ? -pred_gap : pred_gap;
      corr = (gap_abs * w + 32768) / 65536;
      y = xs + ((pred_gap < 0) ? -corr : corr);
      if (y > SAMPLE_MAX) y = SAMPLE_MAX;
      if (y < SAMPLE_MIN) y = SAMPLE_MIN;
    end

    if (pred_frame_pos + 1 >= frame_len) begin
      pred_tail = xs;
      pred_tail_seen = 1'b1;
      pred_chunk_pos = (pred_chunk_pos + 1 >= chunk_len) ? 0 : pred_chunk_pos + 1;
      pred_frame_pos = 0;
      pred_fading = 1'b0;
    end else begin
      pred_frame_pos = pred_frame_pos + 1;
    end

    beat.audio = y[23:0];
    beat.head = head;
    return beat;
  endfunction

  task automatic note_mismatch(input string detail);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at cycle %0d: %s", cycle_count, detail);
  endtask

  // Output checker: every accepted beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (awaited_beats.size() == 0) begin
        note_mismatch($sformatf("unexpected beat, sample_out %0d frame_start %0b",
                                sample_out, frame_start));
      end else begin
        oldest_beat = awaited_beats.pop_front();
        if (sample_out !== oldest_beat.audio)
          note_mismatch($sformatf("sample_out expected %0d got %0d",
                                  oldest_beat.audio, sample_out));
        if (frame_start !== oldest_beat.head)
          note_mismatch($sformatf("frame_start expected %0b got %0b",
                                  oldest_beat.head, frame_start));
      end
    end
  end

  // Send one sample, with random source gaps ahead of it
  task automatic send_sample(input logic signed [23:0] x);
    if ($urandom_range(0, 99) < source_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < source_gap_pct);
    end
    in_valid <= 1'b1;
    sample_in <= x;
    do @(posedge clk); while (in_stall);
    awaited_beats.push_back(predict_declick(x));
  endtask

  task automatic release_input();
    if (in_valid) in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (awaited_beats.size() != 0) @(posedge clk);
  endtask

  // Register write, only once the block has gone idle
  task automatic write_register(input logic [fsd_pkg::CFG_ADDR_W-1:0] addr,
                                input logic [fsd_pkg::CFG_DATA_W-1:0] data);
    release_input();
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (addr == fsd_pkg::REG_FRAME_LENGTH) begin
      pred_frame_len = data;
      clear_seam_state();
    end else begin
      pred_chunk_frames = data[fsd_pkg::CHUNK_W-1:0];
    end
  endtask

  function automatic logic signed [23:0] random_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 24'sh7FFFFF;
          1: return 24'sh800000;
          2: return 24'sh000000;
          default: return 24'shFFFFFF;
        endcase
      end
      1, 2: return 24'($signed($urandom_range(0, 511)) - 256);
      default: return 24'($urandom);
    endcase
  endfunction

  // Full-scale seams in both directions, driving the sums into saturation
  task automatic test_seam_saturation();
    write_register(fsd_pkg::REG_FRAME_LENGTH, 17'd8);
    write_register(fsd_pkg::REG_CHUNK_FRAMES, 17'd1);
    // first frame: no earlier tail, passes unchanged
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_sample(24'sh000000);
    send_sample(24'shFFFFFF);
    send_sample(24'sh000001);
    send_sample(24'sh555555);
    send_sample(24'shAAAAAA);
    send_sample(24'sh7FFFFF);
    // large positive gap, then full-scale samples clip high
    send_sample(24'sh800000);
    repeat (3) send_sample(24'sh7FFFFF);
    repeat (3) send_sample(24'sh000000);
    send_sample(24'sh800000);
    // large negative gap, clipping low
    send_sample(24'sh7FFFFF);
    repeat (3) send_sample(24'sh800000);
    repeat (4) send_sample(24'sh000000);
  endtask

  // Frame length zero acts as one; each sample then lands on the previous tail
  task automatic test_single_sample_frames();
    write_register(fsd_pkg::REG_FRAME_LENGTH, 17'd0);
    repeat (5) send_sample(random_sample());
    write_register(fsd_pkg::REG_FRAME_LENGTH, 17'd1);
    repeat (5) send_sample(random_sample());
  endtask

  // Chunk of zero, chunk above the maximum, and a chunk shrunk mid-count
  task automatic test_chunk_counting();
    write_register(fsd_pkg::REG_FRAME_LENGTH, 17'd0);
    write_register(fsd_pkg::REG_CHUNK_FRAMES, 17'd0);
    repeat (4) send_sample(random_sample());
    write_register(fsd_pkg::REG_CHUNK_FRAMES, 17'd127);
    repeat (70) send_sample(random_sample());
    write_register(fsd_pkg::REG_FRAME_LENGTH, 17'd16);
    write_register(fsd_pkg::REG_CHUNK_FRAMES, 17'd5);
    repeat (16 * 3 + 4) send_sample(random_sample());
    write_register(fsd_pkg::REG_CHUNK_FRAMES, 17'd2);
    repeat (16 * 2) send_sample(random_sample());
  endtask

  // Largest frame and a frame length above the maximum
  task automatic test_frame_length_extremes();
    write_register(fsd_pkg::REG_FRAME_LENGTH, 17'd65536);
    repeat (20) send_sample(random_sample());
    write_register(fsd_pkg::REG_FRAME_LENGTH, 17'h1FFFF);
    repeat (20) send_sample(random_sample());
  endtask

  // Random register settings with random sample content
  task automatic test_random_streams(input int src_pct, input int sink_pct,
                                     input int n_items);
    int sent;
    int burst;
    int unsigned len;
    source_gap_pct = src_pct;
    sink_stall_pct = sink_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 3))
          0: len = $urandom_range(0, 40);
          1: len = $urandom_range(128, 200);
          2: len = ($urandom_range(0, 1) == 0) ? 16 : 255;
          default: len = $urandom_range(16, 64);
        endcase
        write_register(fsd_pkg::REG_FRAME_LENGTH, CFG_W'(len));
      end
      write_register(fsd_pkg::REG_CHUNK_FRAMES,
                     ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 127))
                                                 : CFG_W'($urandom_range(0, 4)));
      if (pred_frame_len > 64 && pred_frame_len < 400)
        burst = int'(pred_frame_len) + int'($urandom_range(10, 40));
      else
        burst = $urandom_range(30, 90);
      repeat (burst) send_sample(random_sample());
      sent += burst;
    end
  endtask

  initial begin
    pred_frame_len = fsd_pkg::FRAME_LEN_RESET;
    pred_chunk_frames = fsd_pkg::CHUNK_RESET;
    clear_seam_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    source_gap_pct = 15;
    sink_stall_pct = 45;
    test_seam_saturation();
    test_single_sample_frames();
    test_chunk_counting();
    test_frame_length_extremes();
    test_random_streams(15, 45, 120);
    test_random_streams(45, 15, 120);
    test_random_streams(0, 0, 120);

    release_input();
    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && awaited_beats.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
